// ===== rtl/core/sharp_pkg.sv =====
// shared types, constants and the per-channel sharpening function
`timescale 1ns / 1ps
package sharp_pkg;

  localparam int unsigned MaxWidth    = 2048;
  localparam int unsigned MaxHeight   = 2048;
  localparam int unsigned KernelSize  = 3;
  localparam int unsigned PixW        = 24;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned CfgW        = 12;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned RowW        = $clog2(MaxHeight);
  localparam int unsigned NumResults  = 4;

  localparam logic [CfgW-1:0] ResetWidth  = CfgW'(640);
  localparam logic [CfgW-1:0] ResetHeight = CfgW'(480);

  // result slots an input can release, in output order
  localparam int unsigned SlotUpMid   = 0;
  localparam int unsigned SlotUpEnd   = 1;
  localparam int unsigned SlotBotMid  = 2;
  localparam int unsigned SlotBotEnd  = 3;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [KernelSize-1:0] col_t;   // index 0 = two rows up, 2 = current row
  typedef col_t [KernelSize-1:0] win_t;   // index 0 = oldest column

  typedef struct packed {
    logic [ChanW-1:0] pixel_red;
    logic [ChanW-1:0] pixel_green;
    logic [ChanW-1:0] pixel_blue;
  } sharp_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [RowW-1:0]  out_row;
    logic [ColW-1:0]  out_col;
    logic             run_last;
    logic             frame_done;
  } sharp_out_t;

  // what the emitter needs to turn one loaded window into results
  typedef struct packed {
    logic [NumResults-1:0] mask;
    logic [RowW-1:0]       row;
    logic [ColW-1:0]       col;
    logic                  up_mid;   // row above the middle row exists
    logic                  up_bot;   // row above the current row exists
    logic                  lf_mid;   // column left of col-1 exists
    logic                  lf_end;   // column left of col exists
  } sharp_job_t;

  // 5*c - u - d - l - r, clamped to 0..255
  function automatic logic [ChanW-1:0] sharp_chan(
    input logic [ChanW-1:0] c,
    input logic [ChanW-1:0] u,
    input logic [ChanW-1:0] d,
    input logic [ChanW-1:0] l,
    input logic [ChanW-1:0] r
  );
    logic signed [11:0] s;
    logic [ChanW-1:0] res;
    s = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
      - $signed({4'b0000, u}) - $signed({4'b0000, d})
      - $signed({4'b0000, l}) - $signed({4'b0000, r});
    if (s < 0) begin
      res = '0;
    end else if (s > 12'sd255) begin
      res = '1;
    end else begin
      res = s[ChanW-1:0];
    end
    return res;
  endfunction

  // limit a written size to 1..max
  function automatic logic [CfgW-1:0] sat_size(
    input logic [CfgW-1:0] v,
    input logic [CfgW-1:0] max
  );
    logic [CfgW-1:0] res;
    if (v == '0) begin
      res = CfgW'(1);
    end else if (v > max) begin
      res = max;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/sharp_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module sharp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read during write returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sharp_col_cell.sv =====
// one window column cell: takes its neighbor's column on every shift
`timescale 1ns / 1ps
module sharp_col_cell import sharp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  col_t col_i,
  output col_t col_o
);

  col_t col_q;
  col_t col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ===== rtl/core/sharp_emit.sv =====
// result sequencer: walks the pending slots of a window and fills the output register
`timescale 1ns / 1ps
module sharp_emit import sharp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  sharp_job_t job_i,
  input  win_t       win_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output sharp_out_t out_data_o
);

  sharp_job_t job_q, job_d;
  logic [NumResults-1:0] mask_q, mask_d;
  logic       out_valid_q, out_valid_d;
  sharp_out_t out_q, out_d;

  logic [NumResults-1:0] sel, rest;
  logic       out_load, issue, bot, endc;
  logic       use_up, use_dn, use_lf, use_rt;
  logic [1:0] cr, ur;
  col_t       ccol, lcol;
  pix_t       pc, pu, pd, pl, pr;

  assign out_load = !out_valid_q || !out_stall_i;
  assign sel      = mask_q & (~mask_q + NumResults'(1));
  assign rest     = mask_q & ~sel;
  assign issue    = (mask_q != '0) && out_load;
  assign free_o   = (mask_q == '0) || (issue && (rest == '0));

  // centre position of the selected slot
  assign bot  = sel[SlotBotMid] | sel[SlotBotEnd];
  assign endc = sel[SlotUpEnd]  | sel[SlotBotEnd];
  assign cr   = bot ? 2'd2 : 2'd1;
  assign ur   = bot ? 2'd1 : 2'd0;
  assign ccol = endc ? win_i[2] : win_i[1];
  assign lcol = endc ? win_i[1] : win_i[0];

  assign use_up = bot ? job_q.up_bot : job_q.up_mid;
  assign use_lf = endc ? job_q.lf_end : job_q.lf_mid;
  assign use_dn = !bot;
  assign use_rt = !endc;

  // missing neighbors are replaced by the centre
  always_comb begin
    pc = ccol[cr];
    pu = use_up ? ccol[ur] : pc;
    pd = use_dn ? ccol[2] : pc;
    pl = use_lf ? lcol[cr] : pc;
    pr = use_rt ? win_i[2][cr] : pc;
  end

  always_comb begin
    out_d.out_red    = sharp_chan(pc[23:16], pu[23:16], pd[23:16], pl[23:16], pr[23:16]);
    out_d.out_green  = sharp_chan(pc[15:8], pu[15:8], pd[15:8], pl[15:8], pr[15:8]);
    out_d.out_blue   = sharp_chan(pc[7:0], pu[7:0], pd[7:0], pl[7:0], pr[7:0]);
    out_d.out_row    = bot ? job_q.row : job_q.row - RowW'(1);
    out_d.out_col    = endc ? job_q.col : job_q.col - ColW'(1);
    out_d.run_last   = (rest == '0);
    out_d.frame_done = sel[SlotBotEnd];
  end

  always_comb begin
    mask_d = mask_q;
    job_d  = job_q;
    if (issue) begin
      mask_d = rest;
    end
    if (load_i) begin
      mask_d = job_i.mask;
      job_d  = job_i;
    end
    out_valid_d = out_load ? issue : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (issue) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/sharpen_3x3_rgb_unit.sv =====
// top level of the streaming 3x3 rgb sharpening filter
`timescale 1ns / 1ps
// Streaming 3x3 sharpen (centre 5, edge neighbors -1, corners 0) on rgb pixels
// in raster order, each channel clamped to 0..255, with the frame border
// replicated. Results carry their row and column and come out in raster order:
// result (r,c) is released by the pixel at (r+1,c+1), the last column by the
// last pixel of the next row, and the bottom row as it arrives, so one request
// releases zero to four results; run_last marks the final one of a request and
// frame_done the bottom-right pixel. Each request passes through the input
// register and then the window, and its results are registered at the output.
// Throughput is one request per clock while each request releases at most one
// result and the output is not stalled; a request releasing more results holds
// the window until all of them have issued, since the single output register
// takes one result per clock (row ends and the bottom row). The output register
// parts the two sides, so a request can be taken while a result waits. The two
// line stores are 2048 x 24 rams with no clearing pass after reset. Writing
// image_width (index 0) or image_height (index 1) saturates to 1..2048 and
// restarts the frame at row 0, column 0; write only while the block is idle.
module sharpen_3x3_rgb_unit import sharp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // pixel requests
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sharp_in_t        in_data_i,
  // results
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sharp_out_t       out_data_o,
  // configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_reg_e         cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i
);

  // frame size and position of the next pixel
  logic [CfgW-1:0] width_q, width_d, height_q, height_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // input stage: pixel waiting for its line store read
  logic            a_valid_q, a_valid_d;
  pix_t            a_px_q;
  logic [RowW-1:0] a_row_q;
  logic [ColW-1:0] a_col_q;
  logic            a_last_col_q, a_last_row_q;
  logic            a_fwd_q, a_fwd_d;
  pix_t            fwd_above_q, fwd_two_q;

  logic       in_accept, cfg_we, b_go, em_free;
  logic       last_col_now, last_row_now;
  pix_t       above_rd, two_rd, a_above, a_two;
  col_t       new_col;
  win_t       win;
  sharp_job_t job;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // the window advances only once the emitter has finished with it
  assign b_go       = a_valid_q && em_free;
  assign in_stall_o = a_valid_q && !b_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign last_col_now = ({1'b0, col_q} == width_q - CfgW'(1));
  assign last_row_now = ({1'b0, row_q} == height_q - CfgW'(1));

  // config registers and position counters
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (in_accept) begin
      if (last_col_now) begin
        col_d = '0;
        row_d = last_row_now ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (cfg_we) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_d  = sat_size(cfg_data_i, CfgW'(MaxWidth));
        REG_IMAGE_HEIGHT: height_d = sat_size(cfg_data_i, CfgW'(MaxHeight));
        default: ;
      endcase
      // any register write restarts the frame
      col_d = '0;
      row_d = '0;
    end
  end

  // same column read while the previous pixel writes it (one pixel per row)
  assign a_fwd_d   = in_accept && b_go && (a_col_q == col_q);
  assign a_valid_d = in_accept ? 1'b1 : (b_go ? 1'b0 : a_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ResetWidth;
      height_q  <= ResetHeight;
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      a_fwd_q   <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= a_valid_d;
      if (in_accept) begin
        a_fwd_q <= a_fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_px_q       <= {in_data_i.pixel_red, in_data_i.pixel_green, in_data_i.pixel_blue};
      a_row_q      <= row_q;
      a_col_q      <= col_q;
      a_last_col_q <= last_col_now;
      a_last_row_q <= last_row_now;
      fwd_above_q  <= a_px_q;
      fwd_two_q    <= a_above;
    end
  end

  // line stores, read on accept and written when the pixel enters the window
  sharp_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_line_above (
    .clk_i   (clk_i),
    .we_i    (b_go),
    .waddr_i (a_col_q),
    .wdata_i (a_px_q),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (above_rd)
  );

  sharp_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_line_two_above (
    .clk_i   (clk_i),
    .we_i    (b_go),
    .waddr_i (a_col_q),
    .wdata_i (a_above),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (two_rd)
  );

  assign a_above = a_fwd_q ? fwd_above_q : above_rd;
  assign a_two   = a_fwd_q ? fwd_two_q : two_rd;

  always_comb begin
    new_col[0] = a_two;
    new_col[1] = a_above;
    new_col[2] = a_px_q;
  end

  // window: chain of column cells, newest column enters on the right
  for (genvar k = 0; k < KernelSize; k++) begin : g_win
    if (k == KernelSize - 1) begin : g_head
      sharp_col_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (b_go),
        .col_i   (new_col),
        .col_o   (win[k])
      );
    end else begin : g_body
      sharp_col_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (b_go),
        .col_i   (win[k+1]),
        .col_o   (win[k])
      );
    end
  end

  // results released by this pixel
  always_comb begin
    job.mask[SlotUpMid]  = (a_row_q != '0) && (a_col_q != '0);
    job.mask[SlotUpEnd]  = (a_row_q != '0) && a_last_col_q;
    job.mask[SlotBotMid] = a_last_row_q && (a_col_q != '0);
    job.mask[SlotBotEnd] = a_last_row_q && a_last_col_q;
    job.row    = a_row_q;
    job.col    = a_col_q;
    job.up_mid = (a_row_q[RowW-1:1] != '0);
    job.up_bot = (a_row_q != '0);
    job.lf_mid = (a_col_q[ColW-1:1] != '0);
    job.lf_end = (a_col_q != '0);
  end

  sharp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (b_go),
    .job_i       (job),
    .win_i       (win),
    .free_o      (em_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/sharp_chk.sv =====
// port level checks for the sharpening filter, bound to the top level
`timescale 1ns / 1ps
module sharp_chk import sharp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  sharp_out_t       out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // the bottom-right pixel is always the last result of its request
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.run_last)
    else $error("frame_done without run_last");

  // results of one request leave back to back
  a_run_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind sharpen_3x3_rgb_unit sharp_chk u_sharp_chk (.*);
